[rtl/core/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// ihex_pkg
// shared types and constants for the hex record parser
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_CHAR  = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_NOCOLON = 4'd1;
    localparam logic [3:0] ST_SHORT   = 4'd2;
    localparam logic [3:0] ST_HDRHEX  = 4'd3;
    localparam logic [3:0] ST_LENGTH  = 4'd4;
    localparam logic [3:0] ST_DATAHEX = 4'd5;
    localparam logic [3:0] ST_CSUM    = 4'd6;
    localparam logic [3:0] ST_RANGE   = 4'd7;
    localparam logic [3:0] ST_ADDRLEN = 4'd8;
    localparam logic [3:0] ST_TYPE    = 4'd9;
    localparam logic [3:0] ST_NODATA  = 4'd10;

    // record types
    localparam logic [7:0] REC_DATA   = 8'h00;
    localparam logic [7:0] REC_EOF    = 8'h01;
    localparam logic [7:0] REC_SEG    = 8'h02;
    localparam logic [7:0] REC_LINEAR = 8'h04;

    localparam logic [7:0] MAX_RECORD_BYTES = 8'd255;
    localparam logic [9:0] LEN_SAT = 10'd1023;

    // result item, packed for the output stream
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] byte_address;
        logic [7:0]  data_value;
        logic [3:0]  status;
        logic [31:0] used_bytes;
        logic        end_of_run;
    } result_t;

    // work passed from the front to the back part
    typedef struct packed {
        logic        has_data;   // tentative data byte first
        logic [31:0] data_addr;
        logic [7:0]  data_val;
        logic        has_rec;    // record or finish second
        logic [1:0]  rec_kind;
        logic [31:0] rec_addr;
        logic [3:0]  rec_status;
        logic [31:0] rec_used;
    } op_t;

    localparam int OP_W = $bits(op_t);
    localparam int RES_W = $bits(result_t);

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = 5'(c[3:0] + 4'd9);
        return v;
    endfunction

endpackage

[rtl/core/ihex_fifo.sv]
// ----------------------------------------------------------------------------
// ihex_fifo
// two-entry queue between the front and the back part
// ----------------------------------------------------------------------------
module ihex_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  ihex_pkg::op_t            in_op,
    output logic                     out_valid,
    input  logic                     out_ready,
    output ihex_pkg::op_t            out_op
);
    ihex_pkg::op_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_op    = mem_reg[rptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= 2'(count_reg + {1'b0, push} - {1'b0, pop});
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("push lost");
    a_pop_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 2'd1)
        else $error("pop lost");
endmodule

[rtl/core/ihex_front.sv]
// ----------------------------------------------------------------------------
// ihex_front
// character decode, line state and record checks
// ----------------------------------------------------------------------------
module ihex_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    func,
    input  logic [7:0]    text_char,
    input  logic [31:0]   flash_limit,
    output logic          op_valid,
    input  logic          op_ready,
    output ihex_pkg::op_t op
);
    localparam logic [1:0] PH_BETWEEN = 2'd0;
    localparam logic [1:0] PH_LINE    = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [9:0]  len_reg, len_next;
    logic [3:0]  nib_reg, nib_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] off_reg, off_next;
    logic [7:0]  typ_reg, typ_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] fdw_reg, fdw_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] used_reg, used_next;
    logic        hbad_reg, hbad_next, dbad_reg, dbad_next;
    logic [31:0] rec_base_reg, rec_base_next; // base + offset of the open line

    logic        acc;
    logic [4:0]  hv;
    logic [3:0]  v;
    logic [7:0]  byte_v;
    logic [8:0]  idx;
    logic        ws, eol;
    logic [3:0]  st;
    logic [31:0] endsum;
    logic [31:0] lim_gap;
    logic [31:0] ext;

    assign in_ready = op_ready;
    assign acc = in_valid && in_ready;
    assign hv = ihex_pkg::hex_value(text_char);
    assign ws = text_char == 8'h20 || text_char == 8'h09 || eol;
    assign eol = text_char == 8'h0d || text_char == 8'h0a;
    assign idx = 9'((len_reg - 10'd8) >> 1);
    assign lim_gap = flash_limit - rec_base_reg;
    // range check passed, so this sum cannot wrap
    assign endsum = rec_base_reg + {24'd0, cnt_reg};
    assign ext = (used_reg < endsum) ? endsum : used_reg;

    // line end verdict
    always_comb
    begin
        st = ihex_pkg::ST_OK;
        if (len_reg < 10'd10) st = ihex_pkg::ST_SHORT;
        else if (hbad_reg) st = ihex_pkg::ST_HDRHEX;
        else if (cnt_reg > ihex_pkg::MAX_RECORD_BYTES
                 || len_reg != 10'd10 + {1'b0, cnt_reg, 1'b0})
            st = ihex_pkg::ST_LENGTH;
        else if (dbad_reg) st = ihex_pkg::ST_DATAHEX;
        else if (sum_reg != 8'd0) st = ihex_pkg::ST_CSUM;
    end

    always_comb
    begin
        phase_next = phase_reg; len_next = len_reg; nib_next = nib_reg;
        cnt_next = cnt_reg; off_next = off_reg; typ_next = typ_reg;
        sum_next = sum_reg; fdw_next = fdw_reg; base_next = base_reg;
        used_next = used_reg; hbad_next = hbad_reg; dbad_next = dbad_reg;
        rec_base_next = rec_base_reg;
        op = '0;
        v = hv[4] ? 4'd0 : hv[3:0];
        byte_v = {nib_reg, v};
        if (acc)
        begin
            if (func == ihex_pkg::FUNC_START)
            begin
                phase_next = PH_BETWEEN; len_next = '0; nib_next = '0; cnt_next = '0;
                off_next = '0; typ_next = '0; sum_next = '0; fdw_next = '0;
                hbad_next = 1'b0; dbad_next = 1'b0; base_next = '0; used_next = '0;
                rec_base_next = '0;
            end
            else if ((func == ihex_pkg::FUNC_CHAR && phase_reg == PH_LINE && eol)
                     || (func == ihex_pkg::FUNC_END && phase_reg == PH_LINE))
            begin
                op.has_rec = 1'b1;
                op.rec_kind = ihex_pkg::KIND_FINISH;
                op.rec_used = used_reg;
                phase_next = PH_DONE;
                if (st != ihex_pkg::ST_OK) op.rec_status = st;
                else
                begin
                    unique case (typ_reg) inside
                        ihex_pkg::REC_DATA:
                        begin
                            if (rec_base_reg > flash_limit || {24'd0, cnt_reg} > lim_gap)
                                op.rec_status = ihex_pkg::ST_RANGE;
                            else
                            begin
                                phase_next = PH_BETWEEN;
                                used_next = ext;
                                op.rec_kind = ihex_pkg::KIND_RECORD;
                                op.rec_addr = rec_base_reg;
                                op.rec_used = ext;
                            end
                        end
                        ihex_pkg::REC_EOF:
                            op.rec_status = (used_reg != 0) ? ihex_pkg::ST_OK
                                                            : ihex_pkg::ST_NODATA;
                        ihex_pkg::REC_SEG, ihex_pkg::REC_LINEAR:
                        begin
                            if (cnt_reg != 8'd2) op.rec_status = ihex_pkg::ST_ADDRLEN;
                            else
                            begin
                                phase_next = PH_BETWEEN;
                                base_next = (typ_reg == ihex_pkg::REC_SEG)
                                            ? {12'd0, fdw_reg, 4'd0}
                                            : {fdw_reg, 16'd0};
                                op.rec_kind = ihex_pkg::KIND_RECORD;
                                op.rec_addr = base_next;
                            end
                        end
                        default: op.rec_status = ihex_pkg::ST_TYPE;
                    endcase
                end
                // end of image after an accepted record: finish follows
                if (func == ihex_pkg::FUNC_END && phase_next == PH_BETWEEN)
                begin
                    op.has_data = 1'b1;
                    op.data_addr = op.rec_addr;
                    op.data_val = 8'hff; // marker: record then finish
                    phase_next = PH_DONE;
                end
            end
            else if (func == ihex_pkg::FUNC_END && phase_reg == PH_BETWEEN)
            begin
                op.has_rec = 1'b1;
                op.rec_kind = ihex_pkg::KIND_FINISH;
                op.rec_status = (used_reg != 0) ? ihex_pkg::ST_OK : ihex_pkg::ST_NODATA;
                op.rec_used = used_reg;
                phase_next = PH_DONE;
            end
            else if (func == ihex_pkg::FUNC_CHAR && phase_reg == PH_BETWEEN)
            begin
                if (text_char == 8'h3a)
                begin
                    phase_next = PH_LINE; len_next = '0; nib_next = '0; cnt_next = '0;
                    off_next = '0; typ_next = '0; sum_next = '0; fdw_next = '0;
                    hbad_next = 1'b0; dbad_next = 1'b0; rec_base_next = base_reg;
                end
                else if (!ws)
                begin
                    op.has_rec = 1'b1;
                    op.rec_kind = ihex_pkg::KIND_FINISH;
                    op.rec_status = ihex_pkg::ST_NOCOLON;
                    op.rec_used = used_reg;
                    phase_next = PH_DONE;
                end
            end
            else if (func == ihex_pkg::FUNC_CHAR && phase_reg == PH_LINE)
            begin
                if (len_reg < ihex_pkg::LEN_SAT) len_next = 10'(len_reg + 10'd1);
                if (len_reg < 10'd8)
                begin
                    if (hv[4]) hbad_next = 1'b1;
                    if (!len_reg[0]) nib_next = v;
                    else
                    begin
                        sum_next = 8'(sum_reg + byte_v);
                        unique case (len_reg[2:1])
                            2'd0: cnt_next = byte_v;
                            2'd1:
                            begin
                                off_next = {byte_v, off_reg[7:0]};
                                rec_base_next = base_reg + {16'd0, off_next};
                            end
                            2'd2:
                            begin
                                off_next = {off_reg[15:8], byte_v};
                                rec_base_next = base_reg + {16'd0, off_next};
                            end
                            default: typ_next = byte_v;
                        endcase
                    end
                end
                else if (idx <= {1'b0, cnt_reg})
                begin
                    if (hv[4]) dbad_next = 1'b1;
                    if (!len_reg[0]) nib_next = v;
                    else
                    begin
                        sum_next = 8'(sum_reg + byte_v);
                        if (idx < {1'b0, cnt_reg})
                        begin
                            if (idx == 9'd0) fdw_next = {byte_v, fdw_reg[7:0]};
                            else if (idx == 9'd1) fdw_next = {fdw_reg[15:8], byte_v};
                            if (typ_reg == ihex_pkg::REC_DATA && !hbad_reg && !dbad_next)
                            begin
                                op.has_data = 1'b1;
                                op.data_addr = rec_base_reg + {23'd0, idx};
                                op.data_val = byte_v;
                            end
                        end
                    end
                end
            end
        end
    end

    assign op_valid = acc && (op.has_data || op.has_rec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BETWEEN; len_reg <= '0; nib_reg <= '0; cnt_reg <= '0;
            off_reg <= '0; typ_reg <= '0; sum_reg <= '0; fdw_reg <= '0;
            base_reg <= '0; used_reg <= '0; hbad_reg <= 1'b0; dbad_reg <= 1'b0;
            rec_base_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next; len_reg <= len_next; nib_reg <= nib_next;
            cnt_reg <= cnt_next; off_reg <= off_next; typ_reg <= typ_next;
            sum_reg <= sum_next; fdw_reg <= fdw_next; base_reg <= base_next;
            used_reg <= used_next; hbad_reg <= hbad_next; dbad_reg <= dbad_next;
            rec_base_reg <= rec_base_next;
        end
    end

    a_phase_ok: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3) else $error("bad phase");
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        acc && phase_reg == PH_DONE && func != ihex_pkg::FUNC_START |-> !op_valid)
        else $error("output after finish");
    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        acc && func == ihex_pkg::FUNC_START |=> used_reg == 0 && base_reg == 0)
        else $error("start did not clear");
endmodule

[rtl/core/ihex_back.sv]
// ----------------------------------------------------------------------------
// ihex_back
// expands queued work into result items with an output register
// ----------------------------------------------------------------------------
module ihex_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  ihex_pkg::op_t         op,
    output logic                  res_valid,
    input  logic                  res_ready,
    output ihex_pkg::result_t     res
);
    ihex_pkg::result_t res_reg, res_next;
    logic              valid_reg;
    logic              second_reg, second_next;   // position in the op
    logic              load, last, fin_after;
    logic              two;

    assign res_valid = valid_reg;
    assign res = res_reg;
    assign load = !valid_reg || res_ready;
    // record followed by an ok/no-data finish, flagged by the front part
    assign fin_after = op.has_data && op.has_rec && op.rec_kind == ihex_pkg::KIND_RECORD
                       && op.data_val == 8'hff && op.data_addr == op.rec_addr;
    assign two = op.has_data && op.has_rec;

    always_comb
    begin
        res_next = '0;
        second_next = second_reg;
        last = 1'b1;
        if (fin_after)
        begin
            if (!second_reg)
            begin
                res_next.kind = ihex_pkg::KIND_RECORD;
                res_next.byte_address = op.rec_addr;
                res_next.used_bytes = op.rec_used;
                last = 1'b0;
            end
            else
            begin
                res_next.kind = ihex_pkg::KIND_FINISH;
                res_next.status = (op.rec_used != 0) ? ihex_pkg::ST_OK
                                                     : ihex_pkg::ST_NODATA;
                res_next.used_bytes = op.rec_used;
                res_next.end_of_run = 1'b1;
            end
        end
        else if (op.has_data && !second_reg)
        begin
            res_next.kind = ihex_pkg::KIND_DATA;
            res_next.byte_address = op.data_addr;
            res_next.data_value = op.data_val;
            last = !two;
            res_next.end_of_run = !two;
        end
        else
        begin
            res_next.kind = op.rec_kind;
            res_next.byte_address = (op.rec_kind == ihex_pkg::KIND_RECORD) ? op.rec_addr : '0;
            res_next.status = op.rec_status;
            res_next.used_bytes = op.rec_used;
            res_next.end_of_run = 1'b1;
        end
        if (op_valid && load) second_next = !last;
    end

    assign op_ready = load && last;

    always_ff @(posedge clk)
    begin
        if (op_valid && load) res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            if (load) valid_reg <= op_valid;
            second_reg <= second_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_reg))
        else $error("result changed under stall");
    a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> op_valid) else $error("second result lost its op");
    a_eor_last: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && load && !last |=> !res_reg.end_of_run)
        else $error("early end of run");
endmodule

[rtl/core/intel_hex_record_parser_core.sv]
// ----------------------------------------------------------------------------
// intel_hex_record_parser_core
// streaming hex image parser, while not stalled one character item per cycle
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries input items: tdata[1:0] func, tdata[9:2] text_char
//   m_axis carries result items; tuser holds kind, tlast marks the last
//   result caused by one input item
//   cfg_valid/cfg_ready/cfg_data write flash_limit (reset 32768); user must write only when idle (not enforced)
// timing:
//   the front part decodes one character item per cycle while the queue has room; its result
//   work goes into a two-entry queue, the back part turns each entry into one or two
//   result items through an output register
//   from accept, a result passes through the queue and then the output register
//   throughput is one item per cycle unless the receiver stalls, except that an item giving
//   two results holds the back part until both results are taken
// reset and stall:
//   reset clears parse state, queue and output; flash_limit returns to 32768
//   when the receiver stalls, the queue fills and s_axis_tready falls
// ----------------------------------------------------------------------------
module intel_hex_record_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // func[1:0], text_char[9:2], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // byte_address[31:0], data_value[39:32],
                                        // status[43:40], used_bytes[75:44], zero fill
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // end_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    logic [31:0]       flash_limit_reg;
    logic              f_valid, f_ready, q_valid, q_ready;
    ihex_pkg::op_t     f_op, q_op;
    ihex_pkg::result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_limit_reg <= 32'd32768;
        end
        else if (cfg_valid)
        begin
            flash_limit_reg <= cfg_data;
        end
    end

    // front: character decode and record checks
    ihex_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .func        (s_axis_tdata[1:0]),
        .text_char   (s_axis_tdata[9:2]),
        .flash_limit (flash_limit_reg),
        .op_valid    (f_valid),
        .op_ready    (f_ready),
        .op          (f_op)
    );

    ihex_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_op     (f_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    // back: result sequencing
    ihex_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_valid),
        .op_ready  (q_ready),
        .op        (q_op),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {4'd0, res.used_bytes, res.status, res.data_value,
                           res.byte_address};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.end_of_run;

    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3) else $error("bad kind");
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ihex_pkg::KIND_FINISH |-> m_axis_tlast)
        else $error("finish not last");
    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ihex_pkg::KIND_FINISH |-> res.status == 4'd0)
        else $error("status on non-finish");
endmodule
